// ----- hdl/skyrp_pkg.sv -----
`timescale 1ns / 1ps

package skyrp_pkg;

   localparam int MAX_SEGMENTS = 64;
   localparam int COORD_BITS   = 13;
   localparam int SEG_IDX_BITS = $clog2(MAX_SEGMENTS);
   localparam int COUNT_BITS   = $clog2(MAX_SEGMENTS + 1);
   localparam int CSR_IDX_BITS = 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ATLAS_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ATLAS_HEIGHT = 1'b1;

   localparam logic [COORD_BITS-1:0] ATLAS_RESET = COORD_BITS'(1024);

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      coord_type rect_width;
      coord_type rect_height;
   } req_type;

   typedef struct packed {
      logic      placed;
      coord_type pos_x;
      coord_type pos_y;
   } rsp_type;

   typedef struct packed {
      coord_type seg_start;
      coord_type seg_top;
   } seg_type;

   typedef enum logic [1:0] {
      ADDR_I,
      ADDR_J,
      ADDR_JN,
      ADDR_K
   } addr_sel_type;

   typedef struct packed {
      logic         start_item;
      logic         rd_en;
      addr_sel_type addr_sel;
      logic         outer_take;
      logic         inner_take;
      logic         cand_done;
      logic         trim_init;
      logic         j_inc;
      logic         copy_init;
      logic         copy_write;
      logic         final_write;
      logic         rsp_ok;
      logic         rsp_fail;
   } ctrl_cmd_type;

   typedef struct packed {
      logic i_lt_count;
      logic fits;
      logic j_lt_count;
      logic in_span;
      logic right_ge_edge;
      logic place_ok;
      logic count_ok;
      logic copy_last;
   } dp_status_type;

endpackage

// ----- hdl/skyline_rect_packer_unit.sv -----
`timescale 1ns / 1ps
// skyline bottom-left rectangle packer
// request: start/busy command channel; an item (rect_width, rect_height) is
// taken at a rising edge with start high and busy low. busy stays high while
// the item is worked on.
// result: rsp_valid is high for exactly one cycle with rsp_item (placed,
// pos_x, pos_y); the receiver cannot stall, so it must take it then.
// busy drops in the same cycle the result is shown, so the next item can be
// started while the result is still on the ports.
// config: csr_we/csr_index/csr_wdata write atlas_width (0) or atlas_height
// (1); write only while busy is low.
// steps: every step is bound by the single read port of the segment memory
// (one registered read per step). each candidate start reads its own segment
// and then the segments inside its span one by one; a start that does not fit
// ends the scan. the end search then reads segment by segment, and each
// segment moved is read and then written back.
// reset: synchronous; the skyline returns to one segment at (0, 0), both
// atlas sizes to 1024, and no result is pending.

module skyline_rect_packer_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  skyrp_pkg::req_type                    req_item,
   output logic                                  rsp_valid,
   output skyrp_pkg::rsp_type                    rsp_item,
   input  logic                                  csr_we,
   input  logic [skyrp_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [skyrp_pkg::COORD_BITS-1:0]      csr_wdata
);

   skyrp_pkg::ctrl_cmd_type  cmd;
   skyrp_pkg::dp_status_type status;

   skyrp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   skyrp_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_item  (rsp_item)
   );

endmodule

// ----- hdl/skyrp_datapath.sv -----
`timescale 1ns / 1ps

module skyrp_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  skyrp_pkg::req_type                    req_item,
   input  logic                                  csr_we,
   input  logic [skyrp_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [skyrp_pkg::COORD_BITS-1:0]      csr_wdata,
   input  skyrp_pkg::ctrl_cmd_type               cmd,
   output skyrp_pkg::dp_status_type              status,
   output skyrp_pkg::rsp_type                    rsp_item
);

   localparam int CB = skyrp_pkg::COORD_BITS;
   localparam int NB = skyrp_pkg::COUNT_BITS;
   localparam int AB = skyrp_pkg::SEG_IDX_BITS;

   skyrp_pkg::seg_type   mem [skyrp_pkg::MAX_SEGMENTS];
   skyrp_pkg::seg_type   rd_ff;
   logic                 rd_zero_ff;
   logic                 e0_valid_ff;
   skyrp_pkg::seg_type   rd;

   skyrp_pkg::coord_type aw_ff, ah_ff, w_ff, h_ff;
   skyrp_pkg::coord_type x_ff, top_ff, best_y_ff, best_x_ff;
   logic [CB:0]          span_ff, edge_ff;
   skyrp_pkg::count_type count_ff, i_ff, j_ff, k_ff, best_idx_ff;
   logic                 found_ff;
   skyrp_pkg::rsp_type   rsp_ff;

   skyrp_pkg::count_type jn, rd_idx, dest_idx;
   logic [AB-1:0]        rd_addr, wr_addr;
   skyrp_pkg::seg_type   wr_data;
   logic                 wr_en;
   logic [CB:0]          start_plus_w, place_top;
   logic [NB:0]          count_next;
   logic                 right_shift;

   assign rd = rd_zero_ff ? '0 : rd_ff;
   assign jn = j_ff + 1'b1;
   assign right_shift = (j_ff == best_idx_ff);

   always_comb begin
      case (cmd.addr_sel)
         skyrp_pkg::ADDR_I:  rd_idx = i_ff;
         skyrp_pkg::ADDR_J:  rd_idx = j_ff;
         skyrp_pkg::ADDR_JN: rd_idx = jn;
         skyrp_pkg::ADDR_K:  rd_idx = k_ff;
         default:            rd_idx = i_ff;
      endcase
   end
   assign rd_addr = rd_idx[AB-1:0];

   assign start_plus_w = {1'b0, rd.seg_start} + {1'b0, w_ff};
   assign place_top    = {1'b0, best_y_ff} + {1'b0, h_ff};
   assign count_next   = {1'b0, count_ff} + 1'b1 - ({1'b0, j_ff} - {1'b0, best_idx_ff});
   // segments from j onward move to just after the new one
   assign dest_idx     = k_ff + best_idx_ff + 1'b1 - j_ff;

   always_comb begin
      wr_en   = cmd.copy_write | cmd.final_write;
      wr_addr = cmd.final_write ? best_idx_ff[AB-1:0] : dest_idx[AB-1:0];
      if (cmd.final_write) begin
         wr_data.seg_start = best_x_ff;
         wr_data.seg_top   = place_top[CB-1:0];
      end else begin
         wr_data.seg_start = (k_ff == j_ff) ? edge_ff[CB-1:0] : rd.seg_start;
         wr_data.seg_top   = rd.seg_top;
      end
   end

   always_comb begin
      status.i_lt_count    = (i_ff < count_ff);
      status.fits          = (start_plus_w <= {1'b0, aw_ff});
      status.j_lt_count    = (j_ff < count_ff);
      status.in_span       = ({1'b0, rd.seg_start} < span_ff);
      status.right_ge_edge = (jn < count_ff) ? ({1'b0, rd.seg_start} >= edge_ff)
                                             : ({1'b0, aw_ff} >= edge_ff);
      status.place_ok      = found_ff && (place_top <= {1'b0, ah_ff});
      status.count_ok      = (count_next <= (NB+1)'(skyrp_pkg::MAX_SEGMENTS));
      status.copy_last     = right_shift ? (k_ff == j_ff) : (k_ff == count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_ff      <= mem[rd_addr];
         rd_zero_ff <= (rd_addr == '0) && !e0_valid_ff;
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aw_ff       <= skyrp_pkg::ATLAS_RESET;
         ah_ff       <= skyrp_pkg::ATLAS_RESET;
         count_ff    <= NB'(1);
         e0_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               skyrp_pkg::CSR_ATLAS_WIDTH:  aw_ff <= csr_wdata;
               skyrp_pkg::CSR_ATLAS_HEIGHT: ah_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (wr_en && wr_addr == '0) begin
            e0_valid_ff <= 1'b1;
         end
         if (cmd.final_write) begin
            count_ff <= count_next[NB-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_item) begin
         w_ff      <= req_item.rect_width;
         h_ff      <= req_item.rect_height;
         i_ff      <= '0;
         best_y_ff <= ah_ff;
         found_ff  <= 1'b0;
      end
      if (cmd.outer_take) begin
         x_ff    <= rd.seg_start;
         span_ff <= start_plus_w;
         j_ff    <= i_ff;
         top_ff  <= '0;
      end
      if (cmd.inner_take) begin
         if (rd.seg_top > top_ff) begin
            top_ff <= rd.seg_top;
         end
         j_ff <= jn;
      end
      if (cmd.cand_done) begin
         if (top_ff < best_y_ff) begin
            best_y_ff   <= top_ff;
            best_idx_ff <= i_ff;
            best_x_ff   <= x_ff;
            found_ff    <= 1'b1;
         end
         i_ff <= i_ff + 1'b1;
      end
      if (cmd.trim_init) begin
         j_ff    <= best_idx_ff;
         edge_ff <= {1'b0, best_x_ff} + {1'b0, w_ff};
      end
      if (cmd.j_inc) begin
         j_ff <= jn;
      end
      if (cmd.copy_init) begin
         k_ff <= right_shift ? count_ff - 1'b1 : j_ff;
      end
      if (cmd.copy_write) begin
         k_ff <= right_shift ? k_ff - 1'b1 : k_ff + 1'b1;
      end
      if (cmd.rsp_ok) begin
         rsp_ff.placed <= 1'b1;
         rsp_ff.pos_x  <= best_x_ff;
         rsp_ff.pos_y  <= best_y_ff;
      end
      if (cmd.rsp_fail) begin
         rsp_ff <= '0;
      end
   end

   assign rsp_item = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= NB'(skyrp_pkg::MAX_SEGMENTS))
      else $error("segment count out of range");

endmodule

// ----- hdl/skyrp_controller.sv -----
`timescale 1ns / 1ps

module skyrp_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   output logic                          rsp_valid,
   input  skyrp_pkg::dp_status_type      status,
   output skyrp_pkg::ctrl_cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_OUT_CHK,
      S_OUT_RD,
      S_OUT_EVAL,
      S_IN_CHK,
      S_IN_RD,
      S_IN_EVAL,
      S_CAND,
      S_PLACE_CHK,
      S_TRIM_CHK,
      S_TRIM_RD,
      S_TRIM_EVAL,
      S_CNT_CHK,
      S_COPY_RD,
      S_COPY_WR,
      S_FINAL
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      cmd.addr_sel = skyrp_pkg::ADDR_I;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.start_item = 1'b1;
               state_in = S_OUT_CHK;
            end
         end
         S_OUT_CHK:  state_in = status.i_lt_count ? S_OUT_RD : S_PLACE_CHK;
         S_OUT_RD: begin
            cmd.rd_en = 1'b1;
            cmd.addr_sel = skyrp_pkg::ADDR_I;
            state_in = S_OUT_EVAL;
         end
         S_OUT_EVAL: begin
            if (status.fits) begin
               cmd.outer_take = 1'b1;
               state_in = S_IN_CHK;
            end else begin
               state_in = S_PLACE_CHK;
            end
         end
         S_IN_CHK:   state_in = status.j_lt_count ? S_IN_RD : S_CAND;
         S_IN_RD: begin
            cmd.rd_en = 1'b1;
            cmd.addr_sel = skyrp_pkg::ADDR_J;
            state_in = S_IN_EVAL;
         end
         S_IN_EVAL: begin
            if (status.in_span) begin
               cmd.inner_take = 1'b1;
               state_in = S_IN_CHK;
            end else begin
               state_in = S_CAND;
            end
         end
         S_CAND: begin
            cmd.cand_done = 1'b1;
            state_in = S_OUT_CHK;
         end
         S_PLACE_CHK: begin
            if (status.place_ok) begin
               cmd.trim_init = 1'b1;
               state_in = S_TRIM_CHK;
            end else begin
               cmd.rsp_fail = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_TRIM_CHK: state_in = status.j_lt_count ? S_TRIM_RD : S_CNT_CHK;
         S_TRIM_RD: begin
            cmd.rd_en = 1'b1;
            cmd.addr_sel = skyrp_pkg::ADDR_JN;
            state_in = S_TRIM_EVAL;
         end
         S_TRIM_EVAL: begin
            if (status.right_ge_edge) begin
               state_in = S_CNT_CHK;
            end else begin
               cmd.j_inc = 1'b1;
               state_in = S_TRIM_CHK;
            end
         end
         S_CNT_CHK: begin
            if (!status.count_ok) begin
               cmd.rsp_fail = 1'b1;
               state_in = S_IDLE;
            end else if (status.j_lt_count) begin
               cmd.copy_init = 1'b1;
               state_in = S_COPY_RD;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_COPY_RD: begin
            cmd.rd_en = 1'b1;
            cmd.addr_sel = skyrp_pkg::ADDR_K;
            state_in = S_COPY_WR;
         end
         S_COPY_WR: begin
            cmd.copy_write = 1'b1;
            state_in = status.copy_last ? S_FINAL : S_COPY_RD;
         end
         S_FINAL: begin
            cmd.final_write = 1'b1;
            cmd.rsp_ok = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.rsp_ok | cmd.rsp_fail;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("item finished without a result");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start");

endmodule

// ----- tb/sv/tb_skyline_rect_packer_unit.sv -----
`timescale 1ns / 1ps

module tb_skyline_rect_packer_unit;
   import skyrp_pkg::*;

   localparam int CYCLE_LIMIT = 100_000_000;
   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

   typedef struct {
      int      w;
      int      h;
      bit      exact;
      rsp_type want;
   } shape_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   req_type                 req_item = '0;
   logic                    rsp_valid;
   rsp_type                 rsp_item;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_ATLAS_WIDTH;
   logic [COORD_BITS-1:0]   csr_wdata = '0;

   // local copy of the skyline and atlas size
   int sky_start [MAX_SEGMENTS];
   int sky_top   [MAX_SEGMENTS];
   int sky_cnt;
   int atlas_w;
   int atlas_h;

   rsp_type placements_due [$];
   int      fail_count;
   int      rects_sent;
   int      rects_placed;
   int      cycle_count;

   skyline_rect_packer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // bottom-left search over the skyline, then the segment list rewrite
   function automatic rsp_type place_rect(req_type r);
      int      w, h, best, best_y, x, y, j, span_end, right, new_cnt, moved;
      bit      found;
      rsp_type o;
      w = r.rect_width;
      h = r.rect_height;
      best = 0;
      best_y = atlas_h;
      found = 0;
      o = '0;
      for (int i = 0; i < sky_cnt; i++) begin
         x = sky_start[i];
         if (x + w > atlas_w) break;
         y = 0;
         for (int k = i; k < sky_cnt && sky_start[k] < x + w; k++)
            if (sky_top[k] > y) y = sky_top[k];
         if (y < best_y) begin
            best_y = y;
            best = i;
            found = 1;
         end
      end
      if (!found || best_y + h > atlas_h) return o;
      x = sky_start[best];
      span_end = x + w;
      j = best;
      while (j < sky_cnt) begin
         right = (j + 1 < sky_cnt) ? sky_start[j + 1] : atlas_w;
         if (right >= span_end) break;
         j++;
      end
      new_cnt = sky_cnt + 1 - (j - best);
      if (new_cnt > MAX_SEGMENTS) return o;
      if (j < sky_cnt) begin
         sky_start[j] = span_end;
         moved = sky_cnt - j;
         if (best + 1 > j) begin
            for (int k = moved - 1; k >= 0; k--) begin
               sky_start[best + 1 + k] = sky_start[j + k];
               sky_top[best + 1 + k] = sky_top[j + k];
            end
         end else begin
            for (int k = 0; k < moved; k++) begin
               sky_start[best + 1 + k] = sky_start[j + k];
               sky_top[best + 1 + k] = sky_top[j + k];
            end
         end
      end
      sky_start[best] = x;
      sky_top[best] = (best_y + h) & COORD_MAX;
      sky_cnt = new_cnt;
      o.placed = 1'b1;
      o.pos_x = COORD_BITS'(x);
      o.pos_y = COORD_BITS'(best_y);
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (placements_due.size() == 0) begin
            $error("result with nothing outstanding: %p", rsp_item);
            fail_count++;
         end else begin
            want = placements_due.pop_front();
            if (rsp_item.placed !== want.placed) begin
               $error("placed: expected %0d, got %0d", want.placed, rsp_item.placed);
               fail_count++;
            end
            if (rsp_item.pos_x !== want.pos_x) begin
               $error("pos_x: expected %0d, got %0d", want.pos_x, rsp_item.pos_x);
               fail_count++;
            end
            if (rsp_item.pos_y !== want.pos_y) begin
               $error("pos_y: expected %0d, got %0d", want.pos_y, rsp_item.pos_y);
               fail_count++;
            end
         end
      end
   end

   task automatic send_rect(int w, int h, bit exact, rsp_type want);
      int      gap;
      req_type r;
      rsp_type pred;
      r.rect_width = COORD_BITS'(w);
      r.rect_height = COORD_BITS'(h);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      pred = place_rect(r);
      if (exact && pred !== want) begin
         $error("skyline copy disagrees with typed row: %p vs %p", pred, want);
         fail_count++;
      end
      placements_due.push_back(exact ? want : pred);
      rects_sent++;
      if (pred.placed) rects_placed++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (placements_due.size() != 0) @(posedge clock);
      do @(posedge clock); while (busy);
   endtask

   task automatic set_atlas(int w, int h);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= CSR_ATLAS_WIDTH;
      csr_wdata <= COORD_BITS'(w);
      @(posedge clock);
      csr_index <= CSR_ATLAS_HEIGHT;
      csr_wdata <= COORD_BITS'(h);
      @(posedge clock);
      csr_we <= 1'b0;
      atlas_w = w & COORD_MAX;
      atlas_h = h & COORD_MAX;
   endtask

   task automatic random_rects(int n, int wmax, int hmax);
      int sel, w, h;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 19);
         if (sel == 0) begin
            w = $urandom_range(0, COORD_MAX);
            h = $urandom_range(0, COORD_MAX);
         end else if (sel == 1) begin
            w = 0;
            h = $urandom_range(0, hmax);
         end else begin
            w = $urandom_range(1, wmax);
            h = $urandom_range(0, hmax);
         end
         send_rect(w, h, 1'b0, '0);
      end
   endtask

   shape_row_type shape_rows [] = '{
      '{0, 5, 1'b1, '{1'b1, 13'd0, 13'd0}},        // zero width at the origin
      '{1024, 1024, 1'b1, '{1'b1, 13'd0, 13'd0}},  // fills the atlas exactly
      '{1, 1, 1'b1, '{1'b0, 13'd0, 13'd0}},        // atlas full
      '{4096, 4096, 1'b1, '{1'b0, 13'd0, 13'd0}},  // oversize
      '{8191, 8191, 1'b1, '{1'b0, 13'd0, 13'd0}},
      '{0, 0, 1'b0, '0},
      '{1025, 0, 1'b1, '{1'b0, 13'd0, 13'd0}},
      '{0, 8191, 1'b0, '0},
      '{5461, 2730, 1'b0, '0},
      '{2730, 5461, 1'b0, '0}
   };

   initial begin
      sky_start = '{default: 0};
      sky_top = '{default: 0};
      sky_cnt = 1;
      atlas_w = 1024;
      atlas_h = 1024;
      fail_count = 0;
      rects_sent = 0;
      rects_placed = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (shape_rows[i])
         send_rect(shape_rows[i].w, shape_rows[i].h, shape_rows[i].exact,
                   shape_rows[i].want);

      // narrow rects in a wide atlas build up to the segment limit
      set_atlas(4096, 4096);
      send_rect(4096, 1, 1'b0, '0);
      random_rects(400, 8, 8);
      set_atlas(16, 8191);
      random_rects(300, 6, 300);
      set_atlas(1, 1);
      random_rects(150, 2, 2);
      set_atlas(8191, 8191);
      random_rects(400, 600, 900);
      set_atlas(300, 4096);
      random_rects(590, 40, 60);

      wait_idle();
      repeat (200) @(posedge clock);
      $display("placed %0d of %0d rects over six atlas sizes", rects_placed, rects_sent);
      $display("skyline ended with %0d segments", sky_cnt);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
